>>> design/s2i_pkg.sv
`default_nettype none
package s2i_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int OFFSET_BITS = 16;
	localparam int BASE_BITS   = 6;
	localparam int PROD_BITS   = VALUE_BITS + BASE_BITS + 1;

	localparam logic [VALUE_BITS-1:0]  VALUE_MAX  = {VALUE_BITS{1'b1}};
	localparam logic [VALUE_BITS-1:0]  SIGNED_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

	localparam logic [BASE_BITS-1:0] BASE_AUTO = BASE_BITS'(0);
	localparam logic [BASE_BITS-1:0] BASE_ONE  = BASE_BITS'(1);
	localparam logic [BASE_BITS-1:0] BASE_OCT  = BASE_BITS'(8);
	localparam logic [BASE_BITS-1:0] BASE_DEC  = BASE_BITS'(10);
	localparam logic [BASE_BITS-1:0] BASE_HEX  = BASE_BITS'(16);
	localparam logic [BASE_BITS-1:0] BASE_TOP  = BASE_BITS'(36);
	localparam logic [BASE_BITS-1:0] NO_DIGIT  = {BASE_BITS{1'b1}};

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7a;

	localparam logic REG_NUMBER_BASE = 1'b0;
	localparam logic REG_SIGNED_MODE = 1'b1;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_BLANK  = 6'b000010,
		PH_SIGNED = 6'b000100,
		PH_ZERO   = 6'b001000,
		PH_PREFIX = 6'b010000,
		PH_DIGITS = 6'b100000
	} s2i_phase_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       start_string;
	} s2i_in_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0]  value;
		logic [OFFSET_BITS-1:0] end_offset;
		logic                   digits_found;
		logic                   out_of_range;
	} s2i_out_t;

	typedef struct packed {
		logic [BASE_BITS-1:0] number_base;
		logic                 signed_mode;
	} s2i_cfg_t;

	typedef struct packed {
		s2i_phase_t             phase;
		logic [VALUE_BITS-1:0]  acc;
		logic [BASE_BITS-1:0]   eb;
		logic                   minus;
		logic                   ovf;
		logic                   dig;
		logic [OFFSET_BITS-1:0] pos;
		logic [OFFSET_BITS-1:0] lgp;
	} s2i_state_t;

	typedef struct packed {
		logic take_item;
		logic load_res;
		logic idle;
	} s2i_ctl_t;

	function automatic logic [BASE_BITS-1:0] digit_of(input logic [7:0] c);
		logic [BASE_BITS-1:0] d;
		d = NO_DIGIT;
		if (c >= CH_0 && c <= CH_9) begin
			d = BASE_BITS'(c - CH_0);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = BASE_BITS'(c - CH_UA + 8'd10);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = BASE_BITS'(c - CH_LA + 8'd10);
		end
		return d;
	endfunction

endpackage
`default_nettype wire

>>> design/s2i_in_stage.sv
`default_nettype none
module s2i_in_stage
	import s2i_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    char_valid,
	output logic         char_ready,
	input  wire s2i_in_t char_item,
	input  wire logic    take_item,
	output logic         valid_s1,
	output s2i_in_t      item_s1
);

	assign char_ready = !valid_s1 || take_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && char_ready) begin
			valid_s1 <= 1'b1;
		end else if (take_item) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			item_s1 <= char_item;
		end
	end

endmodule
`default_nettype wire

>>> design/s2i_core.sv
`default_nettype none
module s2i_core
	import s2i_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire s2i_cfg_t cfg,
	input  wire logic     valid_s1,
	input  wire s2i_in_t  item_s1,
	input  wire logic     res_free,
	output s2i_ctl_t      ctl,
	output s2i_out_t      res
);

	s2i_state_t st_q;
	s2i_state_t nx;
	logic [BASE_BITS-1:0] d;
	logic [PROD_BITS-1:0] prod;
	logic active;
	logic first;
	logic try_digit;
	logic emit;
	logic [7:0] c;

	always_comb begin
		nx        = st_q;
		c         = item_s1.char_byte;
		d         = digit_of(c);
		active    = 1'b1;
		first     = 1'b0;
		try_digit = 1'b0;
		emit      = 1'b0;
		prod      = '0;
		res       = '0;

		if (item_s1.start_string) begin
			nx.phase = PH_BLANK;
			nx.acc   = '0;
			nx.eb    = cfg.number_base;
			nx.minus = 1'b0;
			nx.ovf   = 1'b0;
			nx.dig   = 1'b0;
			nx.pos   = '0;
			nx.lgp   = '0;
			// a radix of one or above thirty-six ends the string at once
			if (cfg.number_base == BASE_ONE || cfg.number_base > BASE_TOP) begin
				active = 1'b0;
				emit   = 1'b1;
			end
		end else if (st_q.phase == PH_IDLE) begin
			active = 1'b0;
		end else if (st_q.pos != OFFSET_MAX) begin
			nx.pos = st_q.pos + 1'b1;
		end

		if (active) begin
			unique case (nx.phase)
				PH_BLANK: begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						nx.minus = (c == CH_MINUS);
						nx.phase = PH_SIGNED;
					end else if (c != CH_SPACE && c != CH_TAB) begin
						first = 1'b1;
					end
				end
				PH_SIGNED: first = 1'b1;
				PH_ZERO: begin
					if (c == CH_LX || c == CH_UX) begin
						nx.eb    = BASE_HEX;
						nx.phase = PH_PREFIX;
					end else begin
						if (nx.eb == BASE_AUTO) nx.eb = BASE_OCT;
						try_digit = 1'b1;
					end
				end
				PH_PREFIX, PH_DIGITS: try_digit = 1'b1;
				default: nx.phase = PH_IDLE;
			endcase
		end

		if (first) begin
			if (c == CH_0 && (nx.eb == BASE_AUTO || nx.eb == BASE_HEX)) begin
				nx.acc   = '0;
				nx.lgp   = (nx.pos == OFFSET_MAX) ? OFFSET_MAX : nx.pos + 1'b1;
				nx.dig   = 1'b1;
				nx.phase = PH_ZERO;
			end else if (nx.eb == BASE_AUTO && d >= BASE_DEC) begin
				emit = 1'b1;
			end else begin
				if (nx.eb == BASE_AUTO) nx.eb = BASE_DEC;
				try_digit = 1'b1;
			end
		end

		if (try_digit) begin
			if (d < nx.eb) begin
				prod = PROD_BITS'(nx.acc) * PROD_BITS'(nx.eb) + PROD_BITS'(d);
				if (!nx.ovf) begin
					if (prod > PROD_BITS'(VALUE_MAX)) nx.ovf = 1'b1;
					else nx.acc = prod[VALUE_BITS-1:0];
				end
				nx.lgp   = (nx.pos == OFFSET_MAX) ? OFFSET_MAX : nx.pos + 1'b1;
				nx.dig   = 1'b1;
				nx.phase = PH_DIGITS;
			end else begin
				emit = 1'b1;
			end
		end

		if (emit) begin
			nx.phase = PH_IDLE;
			if (nx.dig) begin
				res.end_offset   = nx.lgp;
				res.digits_found = 1'b1;
				if (cfg.signed_mode && !nx.minus && (nx.ovf || nx.acc > SIGNED_MAX)) begin
					res.value        = SIGNED_MAX;
					res.out_of_range = 1'b1;
				end else if (cfg.signed_mode && nx.minus &&
						(nx.ovf || nx.acc > SIGNED_MAX + 1'b1)) begin
					res.value        = SIGNED_MAX + 1'b1;
					res.out_of_range = 1'b1;
				end else if (!cfg.signed_mode && nx.ovf) begin
					res.value        = VALUE_MAX;
					res.out_of_range = 1'b1;
				end else begin
					res.value = nx.minus ? (~nx.acc + 1'b1) : nx.acc;
				end
			end
		end
	end

	// hold the item while a finished result cannot be handed on
	assign ctl.take_item = valid_s1 && (!emit || res_free);
	assign ctl.load_res  = valid_s1 && emit && res_free;
	assign ctl.idle      = (st_q.phase == PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_IDLE;
			st_q.acc   <= '0;
			st_q.eb    <= '0;
			st_q.minus <= 1'b0;
			st_q.ovf   <= 1'b0;
			st_q.dig   <= 1'b0;
			st_q.pos   <= '0;
			st_q.lgp   <= '0;
		end else if (ctl.take_item) begin
			st_q <= nx;
		end
	end

endmodule
`default_nettype wire

>>> design/s2i_out_stage.sv
`default_nettype none
module s2i_out_stage
	import s2i_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load_res,
	input  wire s2i_out_t res,
	output logic          res_free,
	output logic          res_valid,
	input  wire logic     res_ready,
	output s2i_out_t      res_item
);

	logic     res_valid_q;
	s2i_out_t res_q;

	assign res_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> design/string_to_integer_parser.sv
// Result path: the item that ends the number passes the input register, then the result register,
// and stalls in the input register while the result register is full and not read; other items give no result.
// Throughput: one item per cycle while no finished result is stalled, set by the accumulator multiply-add
// by the radix with its overflow test between the input and result registers.
// Reset (arst_n low): parser idle, accumulator and offsets cleared, radix 0, signed mode on.
`default_nettype none
module string_to_integer_parser
	import s2i_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 char_valid,
	output logic                      char_ready,
	input  wire s2i_in_t              char_item,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output s2i_out_t                  res_item,
	input  wire logic                 wr_en,
	input  wire logic                 wr_index,
	input  wire logic [BASE_BITS-1:0] wr_data
);

	s2i_cfg_t cfg_q;
	s2i_ctl_t ctl;
	s2i_in_t  item_s1;
	s2i_out_t res;
	logic     valid_s1;
	logic     res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.number_base <= BASE_AUTO;
			cfg_q.signed_mode <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_NUMBER_BASE: cfg_q.number_base <= wr_data;
				REG_SIGNED_MODE: cfg_q.signed_mode <= wr_data[0];
				default: ;
			endcase
		end
	end

	s2i_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.take_item  (ctl.take_item),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	s2i_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.res_free (res_free),
		.ctl      (ctl),
		.res      (res)
	);

	s2i_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_res  (ctl.load_res),
		.res       (res),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	// a finished number always leaves the parser idle
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_res |=> ctl.idle)
		else $error("parser not idle after result");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> char_ready)
		else $error("empty input stage refuses an item");

	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((!res_item.out_of_range || res_item.digits_found) &&
			(res_item.digits_found || res_item.end_offset == '0)))
		else $error("result flags inconsistent");

endmodule
`default_nettype wire
